// ===== design/periodic_task_tick_scheduler_unit_assert.svh =====
// Assertion macros for the periodic task tick scheduler checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef PERIODIC_TASK_TICK_SCHEDULER_UNIT_ASSERT_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptts assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define PTTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptts assertion failed one cycle later");

`endif

// ===== design/ptts_pkg.sv =====
// Shared types and constants for the periodic task tick scheduler.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ptts_pkg;

  localparam int TASKS_DEFAULT = 8;

  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_CREATE  = 3'd1;
  localparam logic [2:0] KIND_DELETE  = 3'd2;
  localparam logic [2:0] KIND_SUSPEND = 3'd3;
  localparam logic [2:0] KIND_RESUME  = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  slot;
    logic [31:0] period;
    logic [31:0] first_delay;
  } in_item_t;

  typedef struct packed {
    logic [7:0] fired_mask;
    logic       status;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // an input beat is taken this cycle
    logic rd_en;    // read slot tables at the scan index
    logic upd_en;   // update the slot read in the previous cycle
    logic finish;   // last update of a tick; emit the fired mask
  } ptts_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tick_req; // the offered beat is a tick
  } ptts_stat_t;

endpackage

// ===== design/ptts_ctrl.sv =====
// Controller for the tick scheduler: handshake and slot scan sequencing.
// Depends on ptts_pkg.
`timescale 1ns / 1ps

module ptts_ctrl #(
  parameter int TASKS = ptts_pkg::TASKS_DEFAULT
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      start,
  output logic                                      busy,
  input  ptts_pkg::ptts_stat_t                      stat,
  output ptts_pkg::ptts_cmd_t                       cmd,
  output logic [((TASKS > 1) ? $clog2(TASKS) : 1)-1:0] rd_idx
);

  localparam int IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASKS - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_TAIL = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  assign busy   = (state_r != ST_IDLE);
  assign rd_idx = idx_r;

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    cmd        = '0;
    cmd.accept = start && !busy;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.accept && stat.tick_req) begin
          state_nxt = ST_SCAN;
          idx_nxt   = '0;
        end
      end
      ST_SCAN: begin
        cmd.rd_en  = 1'b1;
        cmd.upd_en = (idx_r != '0);
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_TAIL;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_TAIL: begin
        cmd.upd_en = 1'b1;
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// ===== design/ptts_dpath.sv =====
// Datapath for the tick scheduler: slot marks, period and countdown tables,
// countdown update and result register. Depends on ptts_pkg.
`timescale 1ns / 1ps

module ptts_dpath #(
  parameter int TASKS = ptts_pkg::TASKS_DEFAULT
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  ptts_pkg::in_item_t                          in_item,
  input  ptts_pkg::ptts_cmd_t                         cmd,
  input  logic [((TASKS > 1) ? $clog2(TASKS) : 1)-1:0] rd_idx,
  output ptts_pkg::ptts_stat_t                        stat,
  output logic                                        out_strobe,
  output ptts_pkg::out_item_t                         out_item
);

  localparam int IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;

  logic [TASKS-1:0] valid_r, valid_nxt;
  logic [TASKS-1:0] susp_r, susp_nxt;

  logic [31:0] cd_mem  [TASKS];
  logic [31:0] per_mem [TASKS];
  logic [31:0] cd_rd_r;
  logic [31:0] per_rd_r;
  logic [IDX_W-1:0] pidx_r;

  logic [7:0] fired_r, fired_nxt;
  logic       strobe_r, strobe_nxt;
  ptts_pkg::out_item_t item_r, item_nxt;

  logic [IDX_W-1:0] slot_idx;
  logic             in_range;
  logic             is_tick, is_create, is_delete, is_suspend, is_resume;
  logic             create_ok;
  logic             create_wr;
  logic             act, fire;
  logic [31:0]      cd_upd;
  logic             cd_we;
  logic [IDX_W-1:0] cd_wa;
  logic [31:0]      cd_wd;

  assign slot_idx   = IDX_W'(in_item.slot);
  assign in_range   = (32'(in_item.slot) < 32'(TASKS));
  assign is_tick    = (in_item.kind == ptts_pkg::KIND_TICK);
  assign is_create  = (in_item.kind == ptts_pkg::KIND_CREATE);
  assign is_delete  = (in_item.kind == ptts_pkg::KIND_DELETE);
  assign is_suspend = (in_item.kind == ptts_pkg::KIND_SUSPEND);
  assign is_resume  = (in_item.kind == ptts_pkg::KIND_RESUME);
  assign create_ok  = is_create && in_range && !valid_r[slot_idx];
  assign create_wr  = cmd.accept && create_ok;

  assign stat.tick_req = is_tick;

  // Commands change the marks of one slot.
  always_comb begin
    valid_nxt = valid_r;
    susp_nxt  = susp_r;
    if (cmd.accept && in_range) begin
      if (create_ok) begin
        valid_nxt[slot_idx] = 1'b1;
        susp_nxt[slot_idx]  = 1'b0;
      end else if (is_delete) begin
        valid_nxt[slot_idx] = 1'b0;
      end else if (is_suspend) begin
        susp_nxt[slot_idx] = 1'b1;
      end else if (is_resume) begin
        susp_nxt[slot_idx] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      susp_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      susp_r  <= susp_nxt;
    end
  end

  // Countdown update for the slot read in the previous cycle.
  assign act    = cmd.upd_en && valid_r[pidx_r] && !susp_r[pidx_r];
  assign fire   = act && (cd_rd_r == 32'd0);
  assign cd_upd = fire ? (per_rd_r - 32'd1) : (cd_rd_r - 32'd1);

  assign fired_nxt = fired_r | (fire ? (8'd1 << pidx_r) : 8'd0);

  assign cd_we = create_wr || act;
  assign cd_wa = create_wr ? slot_idx : pidx_r;
  assign cd_wd = create_wr ? in_item.first_delay : cd_upd;

  always_ff @(posedge clk) begin
    if (cd_we) begin
      cd_mem[cd_wa] <= cd_wd;
    end
    if (cmd.rd_en) begin
      cd_rd_r <= cd_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (create_wr) begin
      per_mem[slot_idx] <= in_item.period;
    end
    if (cmd.rd_en) begin
      per_rd_r <= per_mem[rd_idx];
      pidx_r   <= rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      fired_r <= '0;
    end else if (cmd.upd_en) begin
      fired_r <= fired_nxt;
    end
  end

  // Result register: one beat per command, one per finished tick.
  always_comb begin
    strobe_nxt = (cmd.accept && !is_tick) || cmd.finish;
    item_nxt   = '0;
    if (cmd.finish) begin
      item_nxt.fired_mask = fired_nxt;
    end else begin
      item_nxt.status = is_create && !create_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_item   = item_r;

endmodule

// ===== design/periodic_task_tick_scheduler_unit.sv =====
// Top level of the periodic task tick scheduler.
// Depends on ptts_pkg, ptts_ctrl and ptts_dpath.
`timescale 1ns / 1ps
//
//   Channel   Handshake           Payload                 Accepted when
//   input     start / busy        in_item (in_item_t)     start && !busy
//   result    out_strobe          out_item (out_item_t)   every strobe cycle
//
// A create, delete, suspend or resume beat is carried out at the edge that
// accepts it, and its result is strobed in the next cycle; busy stays low,
// so another beat may follow at once.
// A tick beat scans the slots one per cycle through a single read port on
// the period and countdown tables; busy stays high until the last countdown
// update is done, and the fired mask is strobed as busy falls.
// Reset is synchronous and active low; the slot tables need no clearing
// because the entry of an empty slot is read but never used. The receiver
// cannot stall results.

module periodic_task_tick_scheduler_unit #(
  parameter int TASKS = ptts_pkg::TASKS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  ptts_pkg::in_item_t   in_item,
  output logic                 out_strobe,
  output ptts_pkg::out_item_t  out_item
);

  localparam int IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;

  // The controller owns the handshake and walks the scan index; the
  // datapath holds every slot and does the countdown arithmetic.
  ptts_pkg::ptts_cmd_t  cmd;
  ptts_pkg::ptts_stat_t stat;
  logic [IDX_W-1:0]     rd_idx;

  ptts_ctrl #(
    .TASKS(TASKS)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .stat   (stat),
    .cmd    (cmd),
    .rd_idx (rd_idx)
  );

  // The datapath reads one slot per scan cycle and writes its countdown
  // back in the following cycle, overlapped with the next read.
  ptts_dpath #(
    .TASKS(TASKS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .rd_idx     (rd_idx),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

// ===== design/ptts_checker.sv =====
// Port-level checker for the periodic task tick scheduler, with its bind.
// Depends on ptts_pkg and periodic_task_tick_scheduler_unit_assert.svh.
`timescale 1ns / 1ps
`include "periodic_task_tick_scheduler_unit_assert.svh"

module ptts_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input ptts_pkg::in_item_t  in_item,
  input logic                out_strobe,
  input ptts_pkg::out_item_t out_item
);

  // A command beat answers in the very next cycle.
  `PTTS_ASSERT_NEXT(a_cmd_answers, start && !busy && in_item.kind != ptts_pkg::KIND_TICK, out_strobe)

  // A tick beat makes the block busy for its scan.
  `PTTS_ASSERT_NEXT(a_tick_busy, start && !busy && in_item.kind == ptts_pkg::KIND_TICK, busy)

  // The end of a scan always delivers the fired mask.
  `PTTS_ASSERT_NOW(a_scan_ends_beat, $fell(busy), out_strobe)

  // A refused create never reports fired tasks.
  `PTTS_ASSERT_NOW(a_refused_no_fire, out_strobe && out_item.status, out_item.fired_mask == 8'd0)

endmodule

bind periodic_task_tick_scheduler_unit ptts_checker u_ptts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_item    (in_item),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);

// ===== dv/tb_periodic_task_tick_scheduler_unit.sv =====
// Self-checking testbench for periodic_task_tick_scheduler_unit: directed and random task commands.
// Depends on ptts_pkg and the scheduler RTL; a scoreboard class predicts every result beat.
`timescale 1ns / 1ps

module tb_periodic_task_tick_scheduler_unit;

  localparam int NUM_SLOTS = ptts_pkg::TASKS_DEFAULT;

  // Kinds 5 to 7 have no meaning; the block must answer them with an all-zero result.
  localparam logic [2:0] KIND_RSVD5 = 3'd5;
  localparam logic [2:0] KIND_RSVD6 = 3'd6;
  localparam logic [2:0] KIND_RSVD7 = 3'd7;

  localparam int RANDOM_PER_PHASE = 660;

  // Scoreboard: a private copy of the slot table, and the results still owed by the block.
  class sched_scoreboard;
    bit                  slot_live[NUM_SLOTS];
    bit                  slot_held[NUM_SLOTS];
    logic [31:0]         slot_count[NUM_SLOTS];
    logic [31:0]         slot_reload[NUM_SLOTS];
    ptts_pkg::out_item_t owed_results[$];
    int unsigned         errors;

    // Applies one accepted command to the table and queues the result it must produce.
    function void note_command(ptts_pkg::in_item_t cmd);
      ptts_pkg::out_item_t res;
      bit                  in_range;
      res      = '0;
      in_range = (cmd.slot < NUM_SLOTS);
      case (cmd.kind)
        ptts_pkg::KIND_TICK: begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_live[i] && !slot_held[i]) begin
              if (slot_count[i] == 32'd0) begin
                if (i < 8) res.fired_mask[i] = 1'b1;
                slot_count[i] = slot_reload[i] - 32'd1;
              end else begin
                slot_count[i] = slot_count[i] - 32'd1;
              end
            end
          end
        end
        ptts_pkg::KIND_CREATE: begin
          if (in_range && !slot_live[cmd.slot]) begin
            slot_live[cmd.slot]   = 1'b1;
            slot_held[cmd.slot]   = 1'b0;
            slot_reload[cmd.slot] = cmd.period;
            slot_count[cmd.slot]  = cmd.first_delay;
          end else begin
            res.status = 1'b1;
          end
        end
        ptts_pkg::KIND_DELETE:  if (in_range) slot_live[cmd.slot] = 1'b0;
        ptts_pkg::KIND_SUSPEND: if (in_range) slot_held[cmd.slot] = 1'b1;
        ptts_pkg::KIND_RESUME:  if (in_range) slot_held[cmd.slot] = 1'b0;
        default: ;
      endcase
      owed_results.push_back(res);
    endfunction

    function void check_beat(ptts_pkg::out_item_t got);
      ptts_pkg::out_item_t want;
      if (owed_results.size() == 0) begin
        $display("%0t: result beat with nothing owed, got mask %h status %b",
                 $time, got.fired_mask, got.status);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      if (got.fired_mask !== want.fired_mask) begin
        $display("%0t: fired_mask expected %h actual %h", $time, want.fired_mask,
                 got.fired_mask);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %b actual %b", $time, want.status, got.status);
        errors++;
      end
    endfunction

    function int owed();
      return owed_results.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  ptts_pkg::in_item_t  in_item = '0;
  logic                out_strobe;
  ptts_pkg::out_item_t out_item;

  sched_scoreboard sb = new();
  int unsigned     sender_idle_pct;

  periodic_task_tick_scheduler_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Both channels are sampled at the edge; every driven signal changes only through
  // nonblocking assignments, so the values seen here are the ones the block saw.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) sb.check_beat(out_item);
      if (start && !busy) sb.note_command(in_item);
    end
  end

  // Offers one command beat, waits for the edge that takes it and may then idle. busy is looked at
  // on the falling edge, where it is stable, to decide whether the next edge accepts.
  task automatic send_beat(input ptts_pkg::in_item_t cmd);
    bit taken;
    start   <= 1'b1;
    in_item <= cmd;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end
    if ($urandom_range(99) < sender_idle_pct) begin
      start   <= 1'b0;
      in_item <= ptts_pkg::in_item_t'(70'({$urandom, $urandom, $urandom}));
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sb.owed() != 0) @(posedge clk);
  endtask

  function automatic ptts_pkg::in_item_t make_cmd(logic [2:0] kind, logic [2:0] slot,
                                                  logic [31:0] period, logic [31:0] delay);
    ptts_pkg::in_item_t c;
    c.kind        = kind;
    c.slot        = slot;
    c.period      = period;
    c.first_delay = delay;
    return c;
  endfunction

  // Counts are mostly tiny so that tasks actually fire, with the edges and full-range
  // values mixed in.
  function automatic logic [31:0] pick_count();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return $urandom_range(0, 5);
    if (roll < 80) return 32'd0;
    if (roll < 88) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic ptts_pkg::in_item_t random_command();
    ptts_pkg::in_item_t c;
    int unsigned        roll;
    c.slot        = 3'($urandom_range(7));
    c.period      = pick_count();
    c.first_delay = pick_count();
    roll          = $urandom_range(99);
    if (roll < 45)      c.kind = ptts_pkg::KIND_TICK;
    else if (roll < 63) c.kind = ptts_pkg::KIND_CREATE;
    else if (roll < 73) c.kind = ptts_pkg::KIND_DELETE;
    else if (roll < 82) c.kind = ptts_pkg::KIND_SUSPEND;
    else if (roll < 92) c.kind = ptts_pkg::KIND_RESUME;
    else                c.kind = KIND_RSVD5 + 3'($urandom_range(2));
    return c;
  endfunction

  initial begin
    int unsigned phase_idle[3];
    phase_idle      = '{0, 56, 34};
    sender_idle_pct = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty table, period wrap at zero, refused create, suspend and
    // resume around ticks, marks written on empty slots, and the unused kinds.
    send_beat(make_cmd(ptts_pkg::KIND_TICK, 3'd0, 32'd0, 32'd0));
    send_beat(make_cmd(ptts_pkg::KIND_CREATE, 3'd0, 32'd1, 32'd0));
    send_beat(make_cmd(ptts_pkg::KIND_CREATE, 3'd7, 32'd0, 32'd0));
    send_beat(make_cmd(ptts_pkg::KIND_CREATE, 3'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_beat(make_cmd(ptts_pkg::KIND_CREATE, 3'd0, 32'd2, 32'd2));
    send_beat(make_cmd(ptts_pkg::KIND_TICK, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_beat(make_cmd(ptts_pkg::KIND_TICK, 3'd0, 32'd0, 32'd0));
    send_beat(make_cmd(ptts_pkg::KIND_SUSPEND, 3'd0, 32'd0, 32'd0));
    send_beat(make_cmd(ptts_pkg::KIND_TICK, 3'd0, 32'd0, 32'd0));
    send_beat(make_cmd(ptts_pkg::KIND_RESUME, 3'd0, 32'd0, 32'd0));
    send_beat(make_cmd(ptts_pkg::KIND_TICK, 3'd0, 32'd0, 32'd0));
    send_beat(make_cmd(ptts_pkg::KIND_SUSPEND, 3'd5, 32'd0, 32'd0));
    send_beat(make_cmd(ptts_pkg::KIND_CREATE, 3'd5, 32'd2, 32'd1));
    send_beat(make_cmd(ptts_pkg::KIND_TICK, 3'd0, 32'd0, 32'd0));
    send_beat(make_cmd(ptts_pkg::KIND_DELETE, 3'd3, 32'd0, 32'd0));
    send_beat(make_cmd(ptts_pkg::KIND_DELETE, 3'd4, 32'd0, 32'd0));
    send_beat(make_cmd(ptts_pkg::KIND_RESUME, 3'd2, 32'd0, 32'd0));
    send_beat(make_cmd(ptts_pkg::KIND_CREATE, 3'd3, 32'd3, 32'd0));
    send_beat(make_cmd(KIND_RSVD5, 3'd0, 32'd0, 32'd0));
    send_beat(make_cmd(KIND_RSVD6, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_beat(make_cmd(KIND_RSVD7, 3'd5, 32'd1, 32'd1));
    send_beat(make_cmd(ptts_pkg::KIND_TICK, 3'd0, 32'd0, 32'd0));
    send_beat(make_cmd(ptts_pkg::KIND_TICK, 3'd0, 32'd0, 32'd0));
    send_beat(make_cmd(ptts_pkg::KIND_DELETE, 3'd7, 32'd0, 32'd0));
    send_beat(make_cmd(ptts_pkg::KIND_CREATE, 3'd7, 32'd1, 32'd5));
    wait_drained();

    // Random part in three idling phases; the sender holds off between phases until
    // every owed result has come back.
    foreach (phase_idle[p]) begin
      sender_idle_pct = phase_idle[p];
      repeat (RANDOM_PER_PHASE) send_beat(random_command());
      wait_drained();
    end

    // A stray strobe would show up within one tick scan.
    repeat (NUM_SLOTS + 6) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/ptts_pkg.sv
design/ptts_ctrl.sv
design/ptts_dpath.sv
design/periodic_task_tick_scheduler_unit.sv
design/ptts_checker.sv
dv/tb_periodic_task_tick_scheduler_unit.sv
